[src/i2cm_pkg.sv]
// Shared types and constants for the I2C master bit sequencer.
`default_nettype none
package i2cm_pkg;

	// Bits shifted per byte command
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// Item kinds, also used as the active command code (tick doubles as idle)
	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_START = 3'd1;
	localparam logic [2:0] KIND_STOP  = 3'd2;
	localparam logic [2:0] KIND_WRITE = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;
	localparam logic [2:0] KIND_SACK  = 3'd5;
	localparam logic [2:0] KIND_RACK  = 3'd6;
	localparam logic [2:0] CMD_IDLE   = 3'd0;

	// Sequencer state carried from item to item
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic [2:0] cmd;
		logic [3:0] phase;
		logic [3:0] bits;
		logic [7:0] shift;
		logic [7:0] hold;
		logic       ack;
		logic [7:0] rx;
	} seq_state_t;

	// One input item
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] tx_byte;
		logic       ack_level;
		logic       sda_in;
	} cmd_item_t;

	// One result item
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
		logic       rejected;
	} res_item_t;

endpackage
`default_nettype wire

[src/i2cm_if.sv]
// Valid/ready channel interfaces for commands and results.
`default_nettype none
interface i2cm_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] tx_byte;
	logic       ack_level;
	logic       sda_in;

	modport source (output valid, kind, tx_byte, ack_level, sda_in, input ready);
	modport sink (input valid, kind, tx_byte, ack_level, sda_in, output ready);
endinterface

interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;
	logic       rejected;

	modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
		ack_seen, rejected, input ready);
	modport sink (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
		ack_seen, rejected, output ready);
endinterface
`default_nettype wire

[src/i2cm_step.sv]
// Next-state and result logic for one item of the I2C bit sequencer.
`default_nettype none
module i2cm_step (
	input  var i2cm_pkg::seq_state_t st,
	input  var i2cm_pkg::cmd_item_t  item,
	input  var logic [7:0]           phase_ticks,
	output i2cm_pkg::seq_state_t     nx,
	output i2cm_pkg::res_item_t      res
);

	// Pin levels for the phase the state now points at
	function automatic i2cm_pkg::seq_state_t drive_phase(input i2cm_pkg::seq_state_t s);
		i2cm_pkg::seq_state_t r;
		r = s;
		case (s.cmd)
			i2cm_pkg::KIND_START: begin
				if (s.phase == 4'd0) begin
					r.scl = 1'b1;
					r.sda = 1'b1;
				end else begin
					r.sda = 1'b0;
				end
			end
			i2cm_pkg::KIND_STOP: begin
				if (s.phase == 4'd0) begin
					r.scl = 1'b0;
					r.sda = 1'b0;
				end else if (s.phase == 4'd1) begin
					r.scl = 1'b1;
				end else begin
					r.sda = 1'b1;
				end
			end
			i2cm_pkg::KIND_RACK: begin
				if (s.phase == 4'd0) begin
					r.scl = 1'b0;
					r.sda = 1'b1;
				end else if (s.phase == 4'd1) begin
					r.scl = 1'b1;
				end else begin
					r.scl = 1'b0;
				end
			end
			i2cm_pkg::KIND_SACK: begin
				if (s.phase == 4'd0) begin
					r.scl = 1'b0;
					r.sda = s.shift[0];
				end else if (s.phase == 4'd1) begin
					r.scl = 1'b1;
				end else begin
					r.scl = 1'b0;
					r.sda = 1'b1;
				end
			end
			i2cm_pkg::KIND_WRITE: begin
				if (s.bits >= i2cm_pkg::BITS_PER_BYTE) begin
					r.scl = 1'b0;
					r.sda = 1'b1;
				end else if (s.phase == 4'd0) begin
					r.scl = 1'b0;
					r.sda = s.shift[7];
				end else begin
					r.scl = 1'b1;
				end
			end
			i2cm_pkg::KIND_READ: begin
				if (s.phase == 4'd0) begin
					r.sda = 1'b1;
				end else if (s.phase == 4'd1) begin
					r.scl = 1'b0;
				end else begin
					r.scl = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Close the current phase; fin marks the end of the command
	function automatic i2cm_pkg::seq_state_t finish_phase(input i2cm_pkg::seq_state_t s,
		input logic sda, output logic fin);
		i2cm_pkg::seq_state_t r;
		r   = s;
		fin = 1'b0;
		case (s.cmd)
			i2cm_pkg::KIND_START: begin
				if (s.phase >= 4'd1) fin = 1'b1;
				else r.phase = s.phase + 4'd1;
			end
			i2cm_pkg::KIND_STOP, i2cm_pkg::KIND_SACK, i2cm_pkg::KIND_RACK: begin
				if (s.cmd == i2cm_pkg::KIND_RACK && s.phase == 4'd1) r.ack = sda;
				if (s.phase >= 4'd2) fin = 1'b1;
				else r.phase = s.phase + 4'd1;
			end
			i2cm_pkg::KIND_WRITE: begin
				if (s.bits >= i2cm_pkg::BITS_PER_BYTE) begin
					fin = 1'b1;
				end else if (s.phase == 4'd0) begin
					r.phase = 4'd1;
				end else begin
					r.shift = {s.shift[6:0], 1'b0};
					r.bits  = s.bits + 4'd1;
					r.phase = 4'd0;
				end
			end
			i2cm_pkg::KIND_READ: begin
				if (s.phase >= 4'd2) begin
					r.shift = {s.shift[6:0], sda};
					r.bits  = s.bits + 4'd1;
					if (r.bits >= i2cm_pkg::BITS_PER_BYTE) begin
						r.rx = r.shift;
						fin  = 1'b1;
					end else begin
						r.phase = 4'd1;
					end
				end else begin
					r.phase = s.phase + 4'd1;
				end
			end
			default: fin = 1'b1;
		endcase
		return r;
	endfunction

	logic       done;
	logic       rej;
	logic       fin;
	logic [8:0] hold_next;
	logic [8:0] limit;

	// Command launch or tick advance
	always_comb begin
		nx        = st;
		done      = 1'b0;
		rej       = 1'b0;
		fin       = 1'b0;
		hold_next = {1'b0, st.hold} + 9'd1;
		limit     = (phase_ticks == 8'd0) ? 9'd1 : {1'b0, phase_ticks};
		if (item.kind inside {[i2cm_pkg::KIND_START:i2cm_pkg::KIND_RACK]}) begin
			if (st.cmd != i2cm_pkg::CMD_IDLE) begin
				rej = 1'b1;
			end else begin
				nx.cmd   = item.kind;
				nx.phase = 4'd0;
				nx.bits  = 4'd0;
				nx.hold  = 8'd0;
				case (item.kind)
					i2cm_pkg::KIND_WRITE: nx.shift = item.tx_byte;
					i2cm_pkg::KIND_SACK:  nx.shift = {7'd0, item.ack_level};
					i2cm_pkg::KIND_READ:  nx.shift = 8'd0;
					default: ;
				endcase
				nx = drive_phase(nx);
			end
		end else if (st.cmd != i2cm_pkg::CMD_IDLE) begin
			if (hold_next >= limit) begin
				nx.hold = 8'd0;
				nx = finish_phase(nx, item.sda_in, fin);
				if (fin) begin
					nx.cmd   = i2cm_pkg::CMD_IDLE;
					nx.phase = 4'd0;
					nx.bits  = 4'd0;
					done     = 1'b1;
				end else begin
					nx = drive_phase(nx);
				end
			end else begin
				nx.hold = hold_next[7:0];
			end
		end
	end

	// Result fields follow the updated state
	always_comb begin
		res.scl_level = nx.scl;
		res.sda_level = nx.sda;
		res.busy_res  = (nx.cmd != i2cm_pkg::CMD_IDLE);
		res.done_res  = done;
		res.rx_byte   = nx.rx;
		res.ack_seen  = nx.ack;
		res.rejected  = rej;
	end

endmodule
`default_nettype wire

[src/i2c_master_bit_sequencer.sv]
// Top level of the byte-level I2C master bit sequencer.
//
// Usage: items arrive on cmd_ch (valid/ready); each is a tick (kind 0 or 7) or one
// of start, stop, write byte, read byte, send ack, read ack. Every accepted item
// produces exactly one transaction on res_ch with the driven SCL/SDA levels,
// busy, a done pulse, the last received byte, the last sampled ack and a flag
// for a command that arrived while busy (ignored).
// Each pin phase is held for phase_ticks ticks (reset value 1, zero acts as one),
// set through cfg_we/cfg_wdata; the user must set it only while the sequencer is
// idle, as nothing in the block itself enforces this.
// Each item is captured in the input register, evaluated combinationally, and its
// result captured in the result register, which drives res_ch.
// Throughput: one item per cycle while res_ch takes results; the state update
// between the two registers is combinational.
// When res_ch stalls, the result register holds; an empty input register still
// takes one more item, then cmd_ch.ready drops until the result is taken.
// Reset (arst_n low) releases both lines (SCL and SDA high), returns to idle,
// clears the received byte and ack, and sets phase_ticks to 1.
`default_nettype none
module i2c_master_bit_sequencer (
	input  var logic       clk,
	input  var logic       arst_n,
	i2cm_cmd_if.sink       cmd_ch,
	i2cm_res_if.source     res_ch,
	input  var logic       cfg_we,
	input  var logic [7:0] cfg_wdata
);

	logic                  valid_s1;
	i2cm_pkg::cmd_item_t   item_s1;
	logic                  out_valid_q;
	i2cm_pkg::res_item_t   res_q;
	i2cm_pkg::seq_state_t  state_q;
	i2cm_pkg::seq_state_t  state_nx;
	i2cm_pkg::res_item_t   res_nx;
	logic [7:0]            phase_ticks_q;
	logic                  advance;
	logic                  fire_s1;

	// Pipeline flow control
	assign advance      = !out_valid_q || res_ch.ready;
	assign fire_s1      = valid_s1 && advance;
	assign cmd_ch.ready = !valid_s1 || advance;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= 8'd1;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ch.ready && cmd_ch.valid) begin
			item_s1.kind      <= cmd_ch.kind;
			item_s1.tx_byte   <= cmd_ch.tx_byte;
			item_s1.ack_level <= cmd_ch.ack_level;
			item_s1.sda_in    <= cmd_ch.sda_in;
		end
	end

	// Item evaluation
	i2cm_step u_step (
		.st          (state_q),
		.item        (item_s1),
		.phase_ticks (phase_ticks_q),
		.nx          (state_nx),
		.res         (res_nx)
	);

	// Sequencer state, updated once per evaluated item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.scl   <= 1'b1;
			state_q.sda   <= 1'b1;
			state_q.cmd   <= i2cm_pkg::CMD_IDLE;
			state_q.phase <= 4'd0;
			state_q.bits  <= 4'd0;
			state_q.shift <= 8'd0;
			state_q.hold  <= 8'd0;
			state_q.ack   <= 1'b0;
			state_q.rx    <= 8'd0;
		end else if (fire_s1) begin
			state_q <= state_nx;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_q <= res_nx;
		end
	end

	assign res_ch.valid     = out_valid_q;
	assign res_ch.scl_level = res_q.scl_level;
	assign res_ch.sda_level = res_q.sda_level;
	assign res_ch.busy_res  = res_q.busy_res;
	assign res_ch.done_res  = res_q.done_res;
	assign res_ch.rx_byte   = res_q.rx_byte;
	assign res_ch.ack_seen  = res_q.ack_seen;
	assign res_ch.rejected  = res_q.rejected;

endmodule
`default_nettype wire

[src/i2cm_chk.sv]
// Port-level checker for the I2C master bit sequencer, with its bind.
`default_nettype none
module i2cm_chk (
	input var logic       clk,
	input var logic       arst_n,
	input var logic       res_valid,
	input var logic       res_ready,
	input var logic       scl_level,
	input var logic       sda_level,
	input var logic       busy_res,
	input var logic       done_res,
	input var logic [7:0] rx_byte,
	input var logic       ack_seen,
	input var logic       rejected
);

	// A stalled result stays offered
	a_res_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	// A stalled result keeps its payload
	a_res_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable({scl_level, sda_level, busy_res, done_res,
			rx_byte, ack_seen, rejected}))
		else $error("result payload changed while stalled");

	// Completing a command leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// A command is only turned away while one is running, which then continues
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && rejected |-> busy_res && !done_res)
		else $error("rejection reported while idle or completing");

endmodule

bind i2c_master_bit_sequencer i2cm_chk u_i2cm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_ch.valid),
	.res_ready (res_ch.ready),
	.scl_level (res_ch.scl_level),
	.sda_level (res_ch.sda_level),
	.busy_res  (res_ch.busy_res),
	.done_res  (res_ch.done_res),
	.rx_byte   (res_ch.rx_byte),
	.ack_seen  (res_ch.ack_seen),
	.rejected  (res_ch.rejected)
);
`default_nettype wire
